FILE: sv/tfr_pkg.sv
// Package for the throttle frame receiver: item kinds, register indexes,
// character codes and position mapping constants. No dependencies.
`default_nettype none

package tfr_pkg;

    localparam int TIME_BITS_DEF = 32;

    localparam int CFG_IDX_W  = 2;
    localparam int CFG_DATA_W = 16;
    localparam int STEP_W     = 7;
    localparam int DIGIT_W    = 10;
    localparam int POS_W      = 8;

    typedef enum logic [1:0] {
        KIND_BYTE    = 2'd0,
        KIND_TICK    = 2'd1,
        KIND_PRESS   = 2'd2,
        KIND_RELEASE = 2'd3
    } t_kind;

    typedef enum logic [CFG_IDX_W-1:0] {
        CFG_TIMEOUT     = 2'd0,
        CFG_PRESS_LIMIT = 2'd1,
        CFG_MAX_STEP    = 2'd2
    } t_cfg_reg;

    localparam logic [7:0] CHR_S = 8'h53;
    localparam logic [7:0] CHR_E = 8'h45;
    localparam logic [7:0] CHR_0 = 8'h30;
    localparam logic [7:0] CHR_9 = 8'h39;

    localparam logic [DIGIT_W-1:0] DIGIT_SAT = 10'd1000;
    localparam logic [POS_W-1:0]   POS_MIN   = 8'd90;
    localparam logic [POS_W-1:0]   POS_MAX   = 8'd180;

    localparam logic [15:0]       TIMEOUT_RST  = 16'd1000;
    localparam logic [15:0]       PRESS_RST    = 16'd2000;
    localparam logic [STEP_W-1:0] MAX_STEP_RST = 7'd20;

    // (v-1)*90/999 == ((v-1) * RECIP_MUL) >> RECIP_SHIFT for v-1 in 0..999
    localparam int RECIP_SHIFT = 20;
    localparam logic [16:0] RECIP_MUL = 17'd94470;
    localparam int PROD_W = DIGIT_W + 17;

    typedef struct packed {
        logic             step_held;
        logic             frame_done;
        logic             relay_on;
        logic             motor_power;
        logic [POS_W-1:0] servo_position;
    } t_result;

endpackage

`default_nettype wire

FILE: sv/throttle_frame_receiver.sv
// Throttle frame receiver top level: input register, single-pass update of
// frame, timer and power state, and result register. Depends on tfr_pkg.
`default_nettype none

// Takes one request per cycle (byte, millisecond tick, hall press, hall release) and
// returns exactly one result per request; requests stream back to back at one per
// clock, and the block stalls only while the result register is full and not taken.
// Each result carries the servo position (90..180), motor power, relay level, a flag
// for a completed 'S'..'E' frame and the jump-filter hold flag. Registers are written
// through the cfg channel (index 0 timeout, 1 press limit, 2 max step); the user must
// do so only while no request is in flight, which the block does not enforce. Time
// counters are TIME_BITS wide and wrap.
module throttle_frame_receiver #(
    parameter int TIME_BITS = tfr_pkg::TIME_BITS_DEF
) (
    input  wire logic        i_clk,
    input  wire logic        i_rst_n,
    input  wire logic        s_axis_tvalid,
    output logic             s_axis_tready,
    input  wire logic [7:0]  s_axis_tdata,   // [7:0] rx_byte
    input  wire logic [1:0]  s_axis_tuser,   // [1:0] kind
    output logic             m_axis_tvalid,
    input  wire logic        m_axis_tready,
    output logic [15:0]      m_axis_tdata,   // [7:0] servo_position, [8] motor_power,
                                             // [9] relay_on, [10] frame_done,
                                             // [11] step_held, [15:12] zero
    input  wire logic        i_cfg_valid,
    output logic             o_cfg_ready,
    input  wire logic [tfr_pkg::CFG_IDX_W-1:0]  i_cfg_index,
    input  wire logic [tfr_pkg::CFG_DATA_W-1:0] i_cfg_data
);

    logic                           r_in_vld;
    tfr_pkg::t_kind                 r_kind;
    logic [7:0]                     r_byte;
    logic                           r_out_vld;
    tfr_pkg::t_result               r_res;

    logic [15:0]                    r_timeout;
    logic [15:0]                    r_limit;
    logic [tfr_pkg::STEP_W-1:0]     r_max_step;

    logic [TIME_BITS-1:0]           r_now,   n_now;
    logic [TIME_BITS-1:0]           r_last,  n_last;
    logic [TIME_BITS-1:0]           r_press, n_press;
    logic [tfr_pkg::DIGIT_W-1:0]    r_digit, n_digit;
    logic [tfr_pkg::POS_W-1:0]      r_servo, n_servo;
    logic                           r_hold,  n_hold;
    logic                           r_power, n_power;
    logic                           r_relay, n_relay;
    tfr_pkg::t_result               n_res;

    logic                           w_out_free;
    logic                           w_advance;
    logic [TIME_BITS-1:0]           w_now_inc;
    logic [TIME_BITS-1:0]           w_idle;
    logic [TIME_BITS-1:0]           w_press_len;
    logic [13:0]                    w_acc;
    logic [tfr_pkg::DIGIT_W-1:0]    w_vm1;
    logic [tfr_pkg::PROD_W-1:0]     w_prod;
    logic [tfr_pkg::POS_W-1:0]      w_map;
    logic                           w_is_digit;

    assign w_out_free    = !r_out_vld || m_axis_tready;
    assign w_advance     = r_in_vld && w_out_free;
    assign s_axis_tready = !r_in_vld || w_out_free;
    assign o_cfg_ready   = 1'b1;
    assign m_axis_tvalid = r_out_vld;
    assign m_axis_tdata  = {4'b0000, r_res};

    assign w_now_inc   = r_now + TIME_BITS'(1);
    assign w_idle      = w_now_inc - r_last;
    assign w_press_len = r_now - r_press;
    assign w_is_digit  = (r_byte >= tfr_pkg::CHR_0) && (r_byte <= tfr_pkg::CHR_9);
    assign w_acc       = 14'(r_digit) * 14'd10 + 14'(r_byte[3:0]);
    assign w_vm1       = r_digit - tfr_pkg::DIGIT_W'(1);
    assign w_prod      = tfr_pkg::PROD_W'(w_vm1) * tfr_pkg::PROD_W'(tfr_pkg::RECIP_MUL);
    assign w_map       = (r_digit == '0) ? tfr_pkg::POS_MIN
                       : tfr_pkg::POS_W'(w_prod[tfr_pkg::RECIP_SHIFT +: 7]) + tfr_pkg::POS_MIN;

    always_comb begin
        logic                       f_en;
        logic                       done;
        logic [tfr_pkg::POS_W-1:0]  f_target;
        logic [tfr_pkg::POS_W-1:0]  diff;
        f_en     = 1'b0;
        done     = 1'b0;
        f_target = tfr_pkg::POS_MIN;
        n_now    = r_now;
        n_last   = r_last;
        n_press  = r_press;
        n_digit  = r_digit;
        n_servo  = r_servo;
        n_hold   = r_hold;
        n_power  = r_power;
        n_relay  = r_relay;

        case (r_kind)
            tfr_pkg::KIND_BYTE: begin
                if (r_power) begin
                    if (r_byte == tfr_pkg::CHR_S) begin
                        n_digit = '0;
                    end else if (w_is_digit) begin
                        n_digit = (w_acc > 14'(tfr_pkg::DIGIT_SAT)) ? tfr_pkg::DIGIT_SAT
                                                                   : w_acc[9:0];
                    end else if (r_byte == tfr_pkg::CHR_E) begin
                        f_en     = 1'b1;
                        f_target = w_map;
                        n_digit  = '0;
                        n_last   = r_now;
                        done     = 1'b1;
                    end
                end
            end
            tfr_pkg::KIND_TICK: begin
                n_now = w_now_inc;
                if (r_power && (w_idle > TIME_BITS'(r_timeout))) begin
                    f_en = 1'b1;
                end
            end
            tfr_pkg::KIND_PRESS: begin
                n_press = r_now;
            end
            default: begin
                if (w_press_len > TIME_BITS'(r_limit)) begin
                    n_power = !r_power;
                    n_relay = !r_power;
                end
            end
        endcase

        diff = (r_servo > f_target) ? r_servo - f_target : f_target - r_servo;
        if (f_en) begin
            if ((diff > tfr_pkg::POS_W'(r_max_step)) && !r_hold) begin
                n_hold = 1'b1;
            end else begin
                n_hold  = 1'b0;
                n_servo = f_target;
            end
        end

        n_res.servo_position = n_servo;
        n_res.motor_power    = n_power;
        n_res.relay_on       = n_relay;
        n_res.frame_done     = done;
        n_res.step_held      = n_hold;
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_in_vld   <= 1'b0;
            r_out_vld  <= 1'b0;
            r_timeout  <= tfr_pkg::TIMEOUT_RST;
            r_limit    <= tfr_pkg::PRESS_RST;
            r_max_step <= tfr_pkg::MAX_STEP_RST;
            r_now      <= '0;
            r_last     <= '0;
            r_press    <= '0;
            r_digit    <= '0;
            r_servo    <= tfr_pkg::POS_MIN;
            r_hold     <= 1'b0;
            r_power    <= 1'b1;
            r_relay    <= 1'b0;
        end else begin
            if (s_axis_tready) begin
                r_in_vld <= s_axis_tvalid;
            end
            if (w_out_free) begin
                r_out_vld <= r_in_vld;
            end
            if (i_cfg_valid) begin
                unique case (tfr_pkg::t_cfg_reg'(i_cfg_index))
                    tfr_pkg::CFG_TIMEOUT:     r_timeout  <= i_cfg_data;
                    tfr_pkg::CFG_PRESS_LIMIT: r_limit    <= i_cfg_data;
                    tfr_pkg::CFG_MAX_STEP:    r_max_step <= i_cfg_data[tfr_pkg::STEP_W-1:0];
                    default: ;
                endcase
            end
            if (w_advance) begin
                r_now   <= n_now;
                r_last  <= n_last;
                r_press <= n_press;
                r_digit <= n_digit;
                r_servo <= n_servo;
                r_hold  <= n_hold;
                r_power <= n_power;
                r_relay <= n_relay;
            end
        end
    end

    always_ff @(posedge i_clk) begin
        if (s_axis_tready && s_axis_tvalid) begin
            r_kind <= tfr_pkg::t_kind'(s_axis_tuser);
            r_byte <= s_axis_tdata;
        end
        if (w_advance) begin
            r_res <= n_res;
        end
    end

    a_servo_range: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (r_servo >= tfr_pkg::POS_MIN) && (r_servo <= tfr_pkg::POS_MAX))
        else $error("servo position out of range");

    a_done_needs_power: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (r_out_vld && r_res.frame_done) |-> r_res.motor_power)
        else $error("frame completed with motor power off");

    a_hold_keeps_pos: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        $rose(r_hold) |-> $stable(r_servo))
        else $error("position moved while hold was set");

    a_relay_follows: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (r_relay != $past(r_relay)) |-> (r_relay == r_power))
        else $error("relay changed without following power");

endmodule

`default_nettype wire

FILE: verif/tb_top.sv
// Testbench for throttle_frame_receiver: streams serial bytes, ms ticks and hall
// press/release requests, predicts each servo/power report and checks it field by
// field. Depends on tfr_pkg and the throttle_frame_receiver RTL.
module tb_top;
    timeunit 1ns;
    timeprecision 1ps;

    localparam int unsigned CYCLE_LIMIT  = 200000;
    localparam int unsigned HOLD_CYCLES  = 300;
    localparam int unsigned MAX_REPORTED = 100;

    logic                           i_clk = 1'b0;
    logic                           i_rst_n = 1'b0;
    logic                           s_axis_tvalid = 1'b0;
    logic                           s_axis_tready;
    logic [7:0]                     s_axis_tdata = '0;   // [7:0] rx_byte
    logic [1:0]                     s_axis_tuser = '0;   // [1:0] kind
    logic                           m_axis_tvalid;
    logic                           m_axis_tready = 1'b0;
    logic [15:0]                    m_axis_tdata;        // [7:0] servo_position,
                                                         // [8] motor_power,
                                                         // [9] relay_on, [10] frame_done,
                                                         // [11] step_held
    logic                           i_cfg_valid = 1'b0;
    logic                           o_cfg_ready;
    logic [tfr_pkg::CFG_IDX_W-1:0]  i_cfg_index = '0;
    logic [tfr_pkg::CFG_DATA_W-1:0] i_cfg_data = '0;

    // Predicted block state and registers, starting from their reset values.
    logic [31:0]                 tick_count  = '0;
    logic [31:0]                 frame_stamp = '0;
    logic [31:0]                 press_stamp = '0;
    logic [tfr_pkg::DIGIT_W-1:0] digit_acc   = '0;
    logic [tfr_pkg::POS_W-1:0]   servo_deg   = tfr_pkg::POS_MIN;
    logic                        hold_once   = 1'b0;
    logic                        power_en    = 1'b1;
    logic                        relay_lvl   = 1'b0;
    logic [15:0]                 timeout_lim = tfr_pkg::TIMEOUT_RST;
    logic [15:0]                 press_lim   = tfr_pkg::PRESS_RST;
    logic [tfr_pkg::STEP_W-1:0]  step_lim    = tfr_pkg::MAX_STEP_RST;

    tfr_pkg::t_result reports_q[$];
    int unsigned requests_sent = 0;
    int unsigned bad_reports   = 0;
    int unsigned cycle_count   = 0;
    int unsigned idle_pct      = 0;
    int unsigned stall_pct     = 0;
    int unsigned hold_left     = HOLD_CYCLES;
    logic        hold_go       = 1'b0;

    always begin
        #6 i_clk = 1'b1;
        #6 i_clk = 1'b0;
    end

    throttle_frame_receiver dut (
        .i_clk         (i_clk),
        .i_rst_n       (i_rst_n),
        .s_axis_tvalid (s_axis_tvalid),
        .s_axis_tready (s_axis_tready),
        .s_axis_tdata  (s_axis_tdata),
        .s_axis_tuser  (s_axis_tuser),
        .m_axis_tvalid (m_axis_tvalid),
        .m_axis_tready (m_axis_tready),
        .m_axis_tdata  (m_axis_tdata),
        .i_cfg_valid   (i_cfg_valid),
        .o_cfg_ready   (o_cfg_ready),
        .i_cfg_index   (i_cfg_index),
        .i_cfg_data    (i_cfg_data)
    );

    function automatic logic [tfr_pkg::POS_W-1:0] filter_jump(
        logic [tfr_pkg::POS_W-1:0] cur,
        logic [tfr_pkg::POS_W-1:0] target);
        logic [tfr_pkg::POS_W-1:0] gap;
        gap = (cur > target) ? cur - target : target - cur;
        if (gap > tfr_pkg::POS_W'(step_lim) && !hold_once) begin
            hold_once = 1'b1;
            return cur;
        end
        hold_once = 1'b0;
        return target;
    endfunction

    function automatic tfr_pkg::t_result next_report(tfr_pkg::t_kind kind, logic [7:0] rx);
        tfr_pkg::t_result r;
        int unsigned      acc;
        int unsigned      target;
        logic [31:0]      elapsed;
        r = '0;
        case (kind)
            tfr_pkg::KIND_BYTE: begin
                if (power_en) begin
                    if (rx == tfr_pkg::CHR_S) begin
                        digit_acc = '0;
                    end else if (rx >= tfr_pkg::CHR_0 && rx <= tfr_pkg::CHR_9) begin
                        acc = 32'(digit_acc) * 10 + 32'(rx - tfr_pkg::CHR_0);
                        digit_acc = (acc > 32'(tfr_pkg::DIGIT_SAT)) ? tfr_pkg::DIGIT_SAT
                                                                   : acc[tfr_pkg::DIGIT_W-1:0];
                    end else if (rx == tfr_pkg::CHR_E) begin
                        target = (digit_acc == '0) ? 32'(tfr_pkg::POS_MIN)
                               : (32'(digit_acc) - 1) * 90 / 999 + 32'(tfr_pkg::POS_MIN);
                        servo_deg = filter_jump(servo_deg, target[tfr_pkg::POS_W-1:0]);
                        digit_acc = '0;
                        frame_stamp = tick_count;
                        r.frame_done = 1'b1;
                    end
                end
            end
            tfr_pkg::KIND_TICK: begin
                tick_count = tick_count + 32'd1;
                elapsed = tick_count - frame_stamp;
                if (power_en && elapsed > 32'(timeout_lim))
                    servo_deg = filter_jump(servo_deg, tfr_pkg::POS_MIN);
            end
            tfr_pkg::KIND_PRESS: begin
                press_stamp = tick_count;
            end
            default: begin
                elapsed = tick_count - press_stamp;
                if (elapsed > 32'(press_lim)) begin
                    power_en = !power_en;
                    relay_lvl = power_en;
                end
            end
        endcase
        r.servo_position = servo_deg;
        r.motor_power    = power_en;
        r.relay_on       = relay_lvl;
        r.step_held      = hold_once;
        return r;
    endfunction

    function automatic void check_field(string name, int unsigned want, int unsigned got);
        if (want != got) begin
            if (bad_reports < MAX_REPORTED)
                $error("%s mismatch: expected %0d, actual %0d", name, want, got);
            bad_reports++;
        end
    endfunction

    always @(posedge i_clk) begin
        tfr_pkg::t_result got;
        tfr_pkg::t_result want;
        if (i_rst_n && m_axis_tvalid && m_axis_tready) begin
            got = tfr_pkg::t_result'(m_axis_tdata[11:0]);
            if (reports_q.size() == 0) begin
                $error("report with no request outstanding: tdata %h", m_axis_tdata);
                bad_reports++;
            end else begin
                want = reports_q.pop_front();
                check_field("servo_position", 32'(want.servo_position),
                            32'(got.servo_position));
                check_field("motor_power", 32'(want.motor_power), 32'(got.motor_power));
                check_field("relay_on", 32'(want.relay_on), 32'(got.relay_on));
                check_field("frame_done", 32'(want.frame_done), 32'(got.frame_done));
                check_field("step_held", 32'(want.step_held), 32'(got.step_held));
            end
        end
    end

    // Hold off the report side for a counted stretch, else stall at random.
    always @(posedge i_clk) begin
        if (hold_go && hold_left != 0) begin
            m_axis_tready <= 1'b0;
            hold_left <= hold_left - 1;
        end else begin
            m_axis_tready <= ($urandom_range(99) >= stall_pct);
        end
    end

    always @(posedge i_clk) begin
        cycle_count++;
        if (cycle_count == CYCLE_LIMIT) begin
            $display("timeout after %0d cycles", cycle_count);
            $display("status: fail");
            $finish;
        end
    end

    task automatic send_request(tfr_pkg::t_kind kind, logic [7:0] rx);
        while ($urandom_range(99) < idle_pct) begin
            s_axis_tvalid <= 1'b0;
            @(posedge i_clk);
        end
        s_axis_tvalid <= 1'b1;
        s_axis_tuser  <= kind;
        s_axis_tdata  <= rx;
        do begin
            @(posedge i_clk);
        end while (!s_axis_tready);
        reports_q.push_back(next_report(kind, rx));
        requests_sent++;
    endtask

    task automatic drain_reports();
        s_axis_tvalid <= 1'b0;
        while (reports_q.size() != 0)
            @(posedge i_clk);
    endtask

    task automatic write_register(tfr_pkg::t_cfg_reg idx,
                                  logic [tfr_pkg::CFG_DATA_W-1:0] value);
        i_cfg_valid <= 1'b1;
        i_cfg_index <= idx;
        i_cfg_data  <= value;
        do begin
            @(posedge i_clk);
        end while (!o_cfg_ready);
    endtask

    task automatic load_config(logic [15:0] timeout, logic [15:0] press,
                               logic [tfr_pkg::STEP_W-1:0] step);
        drain_reports();
        write_register(tfr_pkg::CFG_TIMEOUT, timeout);
        write_register(tfr_pkg::CFG_PRESS_LIMIT, press);
        write_register(tfr_pkg::CFG_MAX_STEP, tfr_pkg::CFG_DATA_W'(step));
        i_cfg_valid <= 1'b0;
        timeout_lim = timeout;
        press_lim   = press;
        step_lim    = step;
    endtask

    task automatic send_bytes(string text);
        for (int i = 0; i < text.len(); i++)
            send_request(tfr_pkg::KIND_BYTE, text[i]);
    endtask

    task automatic random_burst();
        int unsigned pick;
        pick = $urandom_range(99);
        if (pick < 45) begin
            send_request(tfr_pkg::KIND_BYTE, tfr_pkg::CHR_S);
            repeat ($urandom_range(5)) begin
                if ($urandom_range(19) == 0)
                    send_request(tfr_pkg::KIND_BYTE, 8'($urandom_range(255)));
                send_request(tfr_pkg::KIND_BYTE, tfr_pkg::CHR_0 + 8'($urandom_range(9)));
            end
            if ($urandom_range(9) != 0)
                send_request(tfr_pkg::KIND_BYTE, tfr_pkg::CHR_E);
        end else if (pick < 65) begin
            repeat ($urandom_range(1, 8))
                send_request(tfr_pkg::KIND_TICK, 8'($urandom_range(255)));
        end else if (pick < 82) begin
            send_request(tfr_pkg::KIND_PRESS, 8'($urandom_range(255)));
            repeat ($urandom_range(8))
                send_request(tfr_pkg::KIND_TICK, 8'($urandom_range(255)));
            send_request(tfr_pkg::KIND_RELEASE, 8'($urandom_range(255)));
        end else begin
            send_request(tfr_pkg::t_kind'($urandom_range(3)), 8'($urandom_range(255)));
        end
    endtask

    task automatic test_frames();
        idle_pct  = 0;
        stall_pct = 0;
        send_bytes("S9999E");
        send_bytes("S500E");
        send_request(tfr_pkg::KIND_BYTE, tfr_pkg::CHR_E);
        send_request(tfr_pkg::KIND_BYTE, 8'h58);
        send_request(tfr_pkg::KIND_BYTE, 8'h00);
        send_request(tfr_pkg::KIND_BYTE, 8'hFF);
    endtask

    task automatic test_power_toggle();
        load_config(16'd0, 16'd0, 7'd90);
        send_request(tfr_pkg::KIND_TICK, 8'h00);
        send_request(tfr_pkg::KIND_RELEASE, 8'h00);
        send_bytes("S1E");
        send_request(tfr_pkg::KIND_TICK, 8'h00);
        send_request(tfr_pkg::KIND_PRESS, 8'h00);
        send_request(tfr_pkg::KIND_TICK, 8'h00);
        send_request(tfr_pkg::KIND_RELEASE, 8'h00);
        send_request(tfr_pkg::KIND_BYTE, tfr_pkg::CHR_E);
    endtask

    task automatic test_random_phase(int unsigned count, int unsigned idle,
                                     int unsigned stall, bit pauses);
        int unsigned stop_at;
        idle_pct  = idle;
        stall_pct = stall;
        stop_at   = requests_sent + count;
        while (requests_sent < stop_at) begin
            random_burst();
            if (pauses && $urandom_range(9) == 0)
                drain_reports();
        end
    endtask

    task automatic test_backpressure();
        int unsigned stop_at;
        idle_pct  = 0;
        stall_pct = 0;
        drain_reports();
        hold_go <= 1'b1;
        stop_at = requests_sent + 60;
        while (requests_sent < stop_at)
            random_burst();
    endtask

    initial begin
        repeat (3) @(posedge i_clk);
        i_rst_n <= 1'b1;
        test_frames();
        test_power_toggle();
        load_config(16'd5, 16'd3, tfr_pkg::MAX_STEP_RST);
        test_random_phase(130, 0, 0, 1'b0);
        load_config(16'd0, 16'd0, 7'd0);
        test_random_phase(130, 69, 0, 1'b0);
        load_config(16'hFFFF, 16'hFFFF, 7'd90);
        test_random_phase(100, 0, 69, 1'b0);
        load_config(16'($urandom_range(12)), 16'($urandom_range(8)), 7'($urandom_range(90)));
        test_random_phase(130, 33, 33, 1'b0);
        load_config(16'($urandom_range(12)), 16'($urandom_range(8)), 7'd37);
        test_random_phase(100, 33, 33, 1'b1);
        test_backpressure();
        stall_pct = 0;
        drain_reports();
        repeat (8) @(posedge i_clk);
        if (bad_reports == 0)
            $display("status: pass");
        else
            $display("status: fail");
        $finish;
    end

endmodule
